>>> rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

    localparam int KEY_W = 32;
    localparam int REQ_W = 2;
    localparam int OCC_W = 5;

    // request codes carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2
    } cell_op_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        cell_op_t                 op;
        logic signed [KEY_W-1:0]  key;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

>>> rtl/skt_cell.sv
`default_nettype none

module skt_cell (
    input  wire                               aclk,
    input  wire skt_pkg::cell_ctrl_t          ctrl,
    input  wire                               occ,
    input  wire                               first_free,
    input  wire                               left_gt,
    input  wire logic signed [skt_pkg::KEY_W-1:0] left_key,
    input  wire logic signed [skt_pkg::KEY_W-1:0] right_key,
    output logic signed [skt_pkg::KEY_W-1:0]  key_q,
    output logic                              gt,
    output logic                              eq
);

    logic signed [skt_pkg::KEY_W-1:0] key_reg;
    logic signed [skt_pkg::KEY_W-1:0] key_next;
    logic                             ge;

    assign key_q = key_reg;
    assign gt    = occ && (key_reg >  ctrl.key);
    assign ge    = occ && (key_reg >= ctrl.key);
    assign eq    = occ && (key_reg == ctrl.key);

    always_comb begin
        key_next = key_reg;
        unique case (ctrl.op)
            skt_pkg::CELL_INSERT: begin
                // take the left key if it moves right, else the new key at the slot
                if (left_gt) begin
                    key_next = left_key;
                end else if (gt || first_free) begin
                    key_next = ctrl.key;
                end
            end
            skt_pkg::CELL_SHIFT: begin
                // close the gap left by the first matching entry
                if (ge) begin
                    key_next = right_key;
                end
            end
            default: begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

`default_nettype wire

>>> rtl/sorted_key_table_unit.sv
// Sorted key table: holds up to CAPACITY signed 32-bit keys in ascending
// order in a row of cells, duplicates allowed. Each request (s_tuser) is an
// insert, a delete of all matching keys, or a find (code 3 changes nothing);
// each answers with one result transaction carrying found, full_drop and the
// occupancy after the request. A request is taken in one cycle and worked
// in the next. A delete steps once per matching entry: the cell row removes
// one match per cycle by shifting its tail one cell to the left. A finished
// result sits in the output register, so a new request is taken while it
// waits; the block only holds in its work state while that register is
// still occupied. Reset empties the table at once; key storage needs no
// clearing.
`default_nettype none

module sorted_key_table_unit #(
    parameter int CAPACITY = 16
) (
    input  wire        aclk,
    input  wire        aresetn,
    // request channel
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [31:0] s_tdata,   // [31:0] key
    input  wire [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata    // [0] found, [1] full_drop, [6:2] occupancy
);

    localparam int CW = $clog2(CAPACITY + 1);

    skt_pkg::state_t                   state_reg, state_next;
    logic [skt_pkg::REQ_W-1:0]         req_reg;
    logic signed [skt_pkg::KEY_W-1:0]  key_reg;
    logic                              found_acc_reg, found_acc_next;
    logic [CW-1:0]                     count_reg, count_next;
    logic                              m_valid_reg, m_valid_next;
    logic [7:0]                        m_data_reg;

    skt_pkg::cell_ctrl_t               ctrl;
    logic signed [skt_pkg::KEY_W-1:0]  keys [CAPACITY];
    logic [CAPACITY-1:0]               occ, first_free, gt_v, eq_v;

    logic        accept, exec, is_del, any_eq, out_free, full;
    logic        del_step, finish, ins_do, res_found, res_drop;
    logic [31:0] occ_wide;

    assign accept   = s_tvalid && s_tready;
    assign exec     = (state_reg == skt_pkg::ST_EXEC);
    assign is_del   = (req_reg == skt_pkg::REQ_DELETE);
    assign any_eq   = |eq_v;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg >= CW'(CAPACITY));

    // a delete keeps stepping while a match is left; every request ends once the output register is free
    assign del_step = exec && is_del && any_eq;
    assign finish   = exec && !del_step && out_free;
    assign ins_do   = finish && (req_reg == skt_pkg::REQ_INSERT) && !full;

    assign res_found = ((req_reg == skt_pkg::REQ_FIND) && any_eq) ||
                       (is_del && found_acc_reg);
    assign res_drop  = (req_reg == skt_pkg::REQ_INSERT) && full;

    always_comb begin
        ctrl.key = key_reg;
        if (ins_do) begin
            ctrl.op = skt_pkg::CELL_INSERT;
        end else if (del_step) begin
            ctrl.op = skt_pkg::CELL_SHIFT;
        end else begin
            ctrl.op = skt_pkg::CELL_HOLD;
        end
    end

    // cell row: each inner cell sees its left and right neighbor; the head sees the request key, the tail itself
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                             l_gt;
        logic signed [skt_pkg::KEY_W-1:0] l_key, r_key;

        assign occ[i]        = (CW'(i) < count_reg);
        assign first_free[i] = (CW'(i) == count_reg);

        if (i == 0) begin : g_head
            assign l_gt  = 1'b0;
            assign l_key = key_reg;
        end else begin : g_mid
            assign l_gt  = gt_v[i-1];
            assign l_key = keys[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign r_key = keys[i];
        end else begin : g_body
            assign r_key = keys[i+1];
        end

        skt_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occ        (occ[i]),
            .first_free (first_free[i]),
            .left_gt    (l_gt),
            .left_key   (l_key),
            .right_key  (r_key),
            .key_q      (keys[i]),
            .gt         (gt_v[i]),
            .eq         (eq_v[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (ins_do) begin
            count_next = count_reg + CW'(1);
        end else if (del_step) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign occ_wide = 32'(count_next);

    always_comb begin
        state_next     = state_reg;
        found_acc_next = found_acc_reg;
        m_valid_next   = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            skt_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next     = skt_pkg::ST_EXEC;
                    found_acc_next = 1'b0;
                end
            end
            skt_pkg::ST_EXEC: begin
                if (del_step) begin
                    found_acc_next = 1'b1;
                end else if (finish) begin
                    state_next   = skt_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = skt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= skt_pkg::ST_IDLE;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
            found_acc_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
            found_acc_reg <= found_acc_next;
        end
    end

    // payload: hold the request, load the result on finish
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_tuser;
            key_reg <= s_tdata;
        end
        if (finish) begin
            m_data_reg <= {1'b0, occ_wide[skt_pkg::OCC_W-1:0], res_drop, res_found};
        end
    end

    assign s_tready = (state_reg == skt_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // occupancy never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // an accepted request always moves to the work state
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> exec)
        else $error("accepted request not worked");

    // a refused insert reports a full table
    localparam int CAP_WIDE = CAPACITY;
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> (m_tdata[6:2] == CAP_WIDE[4:0]))
        else $error("full_drop with table not full");

    // held keys stay in ascending order
    for (genvar j = 0; j < CAPACITY - 1; j++) begin : g_order
        a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
            occ[j+1] |-> (keys[j] <= keys[j+1]))
            else $error("table out of order");
    end

endmodule

`default_nettype wire

>>> verif/sorted_key_table_unit_test.sv
`default_nettype none

module sorted_key_table_unit_test;

    localparam int CAPACITY   = 16;
    localparam int RANDOM_CNT = 550;
    // Idling stops once fewer than this many requests are still pending.
    localparam int CALM_TAIL  = 60;
    // Cycles allowed after the last result, enough for a delete that empties
    // a full table.
    localparam int SETTLE_CYC = 48;
    // Request code with no operation behind it.
    localparam logic [skt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [skt_pkg::REQ_W-1:0]        req;
        logic signed [skt_pkg::KEY_W-1:0] key;
        bit                               drain_first;  // hold until every answer is back
    } request_t;

    typedef struct {
        logic [skt_pkg::REQ_W-1:0]        req;
        logic signed [skt_pkg::KEY_W-1:0] key;
        logic                             found;
        logic                             full_drop;
        logic [skt_pkg::OCC_W-1:0]        occupancy;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;     // [31:0] key
    logic [1:0]       s_tuser = '0;     // [1:0] req_type
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;          // [0] found, [1] full_drop, [6:2] occupancy

    sorted_key_table_unit #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    request_t request_queue[$];
    answer_t  answer_queue[$];

    // Shadow copy of the key table, kept in ascending order.
    logic signed [skt_pkg::KEY_W-1:0] table_keys[CAPACITY];
    int unsigned                      table_count = 0;

    int unsigned item_total     = 0;
    int unsigned accepted_total = 0;
    int unsigned checked_total  = 0;
    int unsigned error_count    = 0;

    // Coverage tallies for the closing summary.
    int unsigned n_insert = 0, n_drop = 0, n_delete = 0, n_removed = 0;
    int unsigned n_find = 0, n_hit = 0, n_unused = 0, peak_count = 0;

    logic signed [skt_pkg::KEY_W-1:0] key_pool[10];

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Apply one request to the shadow table and return the answer it earns.
    function automatic answer_t table_apply(logic [skt_pkg::REQ_W-1:0] req,
                                            logic signed [skt_pkg::KEY_W-1:0] key);
        answer_t     ans;
        int unsigned pos;
        int unsigned kept;
        ans.req       = req;
        ans.key       = key;
        ans.found     = 1'b0;
        ans.full_drop = 1'b0;
        case (req)
            skt_pkg::REQ_INSERT: begin
                n_insert++;
                if (table_count >= CAPACITY) begin
                    ans.full_drop = 1'b1;
                    n_drop++;
                end else begin
                    // land after every key equal to the new one
                    pos = table_count;
                    for (int i = 0; i < table_count; i++) begin
                        if (table_keys[i] > key) begin
                            pos = i;
                            break;
                        end
                    end
                    for (int i = table_count; i > pos; i--)
                        table_keys[i] = table_keys[i-1];
                    table_keys[pos] = key;
                    table_count++;
                end
            end
            skt_pkg::REQ_DELETE: begin
                n_delete++;
                kept = 0;
                for (int i = 0; i < table_count; i++) begin
                    if (table_keys[i] == key) begin
                        ans.found = 1'b1;
                        n_removed++;
                    end else begin
                        table_keys[kept] = table_keys[i];
                        kept++;
                    end
                end
                table_count = kept;
            end
            skt_pkg::REQ_FIND: begin
                n_find++;
                for (int i = 0; i < table_count; i++) begin
                    if (table_keys[i] == key) begin
                        ans.found = 1'b1;
                        break;
                    end
                end
                if (ans.found) n_hit++;
            end
            default: n_unused++;
        endcase
        if (table_count > peak_count) peak_count = table_count;
        ans.occupancy = table_count[skt_pkg::OCC_W-1:0];
        return ans;
    endfunction

    task automatic queue_request(logic [skt_pkg::REQ_W-1:0] req,
                                 logic signed [skt_pkg::KEY_W-1:0] key,
                                 bit drain_first);
        request_t r;
        r.req         = req;
        r.key         = key;
        r.drain_first = drain_first;
        request_queue.push_back(r);
        item_total++;
    endtask

    // Request driver: present the next pending request whenever the previous
    // transaction is done, with random idle bursts until the tail of the run.
    int unsigned gap_left     = 0;
    int unsigned gap_pct      = 0;
    int unsigned driven_total = 0;

    always @(posedge aclk) begin : request_driver
        request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() == 0 ||
                         (request_queue[0].drain_first &&
                          (s_tvalid || answer_queue.size() != 0))) begin
                // nothing left, or hold until every answer has come back
                s_tvalid <= 1'b0;
            end else begin
                nxt = request_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.key;
                s_tuser  <= nxt.req;
                driven_total++;
                // redraw the idle rate now and then, leaving calm stretches
                if (driven_total % 32 == 0)
                    gap_pct = ($urandom_range(0, 1) != 0) ? 25 : 0;
                if (request_queue.size() >= CALM_TAIL && $urandom_range(0, 99) < gap_pct)
                    gap_left = $urandom_range(1, 10);
            end
        end
    end

    // Result monitor: predict on every accepted request, check every accepted
    // result against the oldest prediction, and drive back-pressure.
    int unsigned stall_left = 0;
    int unsigned stall_pct  = 0;
    int unsigned cycle_cnt  = 0;

    always @(posedge aclk) begin : result_monitor
        answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            cycle_cnt++;
            if (s_tvalid && s_tready) begin
                answer_queue.push_back(table_apply(s_tuser, $signed(s_tdata)));
                accepted_total++;
            end
            if (m_tvalid && m_tready) begin
                checked_total++;
                if (answer_queue.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: unexpected result transaction, m_tdata %h", m_tdata);
                end else begin
                    want = answer_queue.pop_front();
                    if (m_tdata[0] !== want.found || m_tdata[1] !== want.full_drop ||
                        m_tdata[6:2] !== want.occupancy) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"ERROR: req %0d key %0d: expected found %b full_drop %b ",
                                      "occupancy %0d, got found %b full_drop %b occupancy %0d"},
                                     want.req, want.key, want.found, want.full_drop,
                                     want.occupancy, m_tdata[0], m_tdata[1], m_tdata[6:2]);
                    end
                end
            end
            if (cycle_cnt % 128 == 0)
                stall_pct = ($urandom_range(0, 1) != 0) ? 8 : 0;
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (request_queue.size() >= CALM_TAIL && $urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    // Stimulus and end of run.
    initial begin : stimulus
        int unsigned roll;
        logic [skt_pkg::REQ_W-1:0] req;
        logic signed [skt_pkg::KEY_W-1:0] key;

        // Operations on an empty table, the unused code included.
        queue_request(skt_pkg::REQ_FIND,   0, 1'b0);
        queue_request(skt_pkg::REQ_DELETE, 0, 1'b0);
        queue_request(REQ_UNUSED, 32'sh8000_0000, 1'b0);
        // Fill to capacity with extremes and duplicates at head, middle and tail.
        queue_request(skt_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 32'sh8000_0000, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 0, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 32'sh8000_0000, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, -1, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 1, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 32'sh8000_0000, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 0, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 100, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, -100, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 7, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 7, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 32'sh7FFF_FFFE, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 32'sh8000_0001, 1'b0);
        queue_request(skt_pkg::REQ_INSERT, 42, 1'b0);
        // Table is full: this insert must be refused.
        queue_request(skt_pkg::REQ_INSERT, 5, 1'b0);
        queue_request(REQ_UNUSED, 0, 1'b0);
        queue_request(skt_pkg::REQ_FIND,   32'sh7FFF_FFFF, 1'b0);
        queue_request(skt_pkg::REQ_FIND,   12345, 1'b0);
        // Remove repeated matches at the head, in the middle and at the tail.
        queue_request(skt_pkg::REQ_DELETE, 32'sh8000_0000, 1'b0);
        queue_request(skt_pkg::REQ_DELETE, 7, 1'b0);
        queue_request(skt_pkg::REQ_DELETE, 32'sh7FFF_FFFF, 1'b0);

        // A small pool of keys makes duplicates, full tables and hits common.
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFF;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        key_pool[5] = 32'sh8000_0001;
        key_pool[6] = 32'sh7FFF_FFFE;
        for (int i = 7; i < 10; i++) key_pool[i] = $signed($urandom);

        // Random requests in phases that fill, drain, or mix.
        for (int i = 0; i < RANDOM_CNT; i++) begin
            roll = $urandom_range(0, 99);
            case ((i / 50) % 3)
                0:       req = (roll < 65) ? skt_pkg::REQ_INSERT :
                               (roll < 85) ? skt_pkg::REQ_FIND :
                               (roll < 95) ? skt_pkg::REQ_DELETE : REQ_UNUSED;
                1:       req = (roll < 25) ? skt_pkg::REQ_INSERT :
                               (roll < 65) ? skt_pkg::REQ_DELETE :
                               (roll < 95) ? skt_pkg::REQ_FIND : REQ_UNUSED;
                default: req = (roll < 40) ? skt_pkg::REQ_INSERT :
                               (roll < 65) ? skt_pkg::REQ_DELETE :
                               (roll < 95) ? skt_pkg::REQ_FIND : REQ_UNUSED;
            endcase
            key = ($urandom_range(0, 99) < 75) ? key_pool[$urandom_range(0, 9)]
                                               : $signed($urandom);
            queue_request(req, key, (i == 0 || i == 300));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every request to be taken, every answer to arrive, then settle.
        while (accepted_total != item_total) @(posedge aclk);
        while (answer_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);

        if (answer_queue.size() != 0) begin
            error_count += answer_queue.size();
            $display("ERROR: %0d expected results never arrived", answer_queue.size());
        end
        $display({"Ran %0d requests: %0d inserts (%0d refused on a full table), ",
                  "%0d deletes (%0d keys removed), %0d finds (%0d hits), %0d unused codes."},
                 item_total, n_insert, n_drop, n_delete, n_removed, n_find, n_hit, n_unused);
        $display("Peak occupancy %0d of %0d, %0d results checked, %0d mismatches.",
                 peak_count, CAPACITY, checked_total, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin : watchdog
        #2000000;
        $display("ERROR: timeout with %0d requests pending and %0d answers outstanding",
                 request_queue.size(), answer_queue.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> sorted_key_table_unit.f
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table_unit.sv
verif/sorted_key_table_unit_test.sv
